FILE: design/esseq_pkg.sv
// ----------------------------------------------------------------------------
// esseq_pkg
// Shared types and constants of the engine start sequencer: phase and mode
// codes, register map, reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
package esseq_pkg;

    localparam int TIMER_W = 16;
    localparam int DEB_W   = 10;
    localparam int AGE_W   = 11;
    localparam int PHASE_W = 3;
    localparam int MODE_W  = 2;
    localparam int REG_W   = 3;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ACC     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_IG      = 3'd2;
    localparam logic [PHASE_W-1:0] PH_STARTER = 3'd3;
    localparam logic [PHASE_W-1:0] PH_COUNT   = 3'd4;

    // item kinds
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRIG = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ENG  = 2'd2;

    // register indexes
    localparam logic [REG_W-1:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [REG_W-1:0] REG_COUNTDOWN = 3'd1;
    localparam logic [REG_W-1:0] REG_ACC_WAIT  = 3'd2;
    localparam logic [REG_W-1:0] REG_IG_WAIT   = 3'd3;
    localparam logic [REG_W-1:0] REG_STARTER   = 3'd4;
    localparam logic [REG_W-1:0] REG_SLOW      = 3'd5;
    localparam logic [REG_W-1:0] REG_FAST_ON   = 3'd6;
    localparam logic [REG_W-1:0] REG_FAST_OFF  = 3'd7;

    // register reset values
    localparam logic [DEB_W-1:0]   RST_DEBOUNCE  = 10'd50;
    localparam logic [TIMER_W-1:0] RST_COUNTDOWN = 16'd15000;
    localparam logic [TIMER_W-1:0] RST_ACC_WAIT  = 16'd1000;
    localparam logic [TIMER_W-1:0] RST_IG_WAIT   = 16'd1000;
    localparam logic [TIMER_W-1:0] RST_STARTER   = 16'd1000;
    localparam logic [TIMER_W-1:0] RST_SLOW      = 16'd500;
    localparam logic [TIMER_W-1:0] RST_FAST_ON   = 16'd200;
    localparam logic [TIMER_W-1:0] RST_FAST_OFF  = 16'd50;

    typedef struct packed {
        logic [DEB_W-1:0]   debounce_ms;
        logic [TIMER_W-1:0] countdown_ms;
        logic [TIMER_W-1:0] acc_wait_ms;
        logic [TIMER_W-1:0] ig_wait_ms;
        logic [TIMER_W-1:0] starter_pulse_ms;
        logic [TIMER_W-1:0] slow_blink_ms;
        logic [TIMER_W-1:0] fast_on_ms;
        logic [TIMER_W-1:0] fast_off_ms;
    } t_cfg;

    typedef struct packed {
        logic press;
        logic release_edge;
    } t_btn_evt;

    // first member sits in the top bits
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               engine_running;
        logic               engine_report_value;
        logic               engine_report_valid;
        logic               reset_pulse;
        logic               led_out;
        logic               starter_out;
        logic               ig_out;
        logic               acc_out;
    } t_result;

endpackage

FILE: design/esseq_debounce.sv
// ----------------------------------------------------------------------------
// esseq_debounce
// Button debouncer: tracks the raw level and its stable age, and flags an
// accepted press or release edge on the tick that qualifies it.
// ----------------------------------------------------------------------------
module esseq_debounce (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_level,
    input  logic [esseq_pkg::DEB_W-1:0]   i_debounce_ms,
    output esseq_pkg::t_btn_evt           o_evt
);

    logic                        r_raw_last;
    logic                        r_stable_level;
    logic [esseq_pkg::AGE_W-1:0] r_stable_age;

    logic                        n_raw_last;
    logic                        n_stable_level;
    logic [esseq_pkg::AGE_W-1:0] n_stable_age;
    logic                        fire;

    always_comb begin
        n_raw_last   = r_raw_last;
        n_stable_age = r_stable_age;
        if (i_level != r_raw_last) begin
            n_raw_last   = i_level;
            n_stable_age = '0;
        end else if (r_stable_age < esseq_pkg::AGE_MAX) begin
            n_stable_age = r_stable_age + 1'b1;
        end
        fire = (n_stable_age > {1'b0, i_debounce_ms}) && (i_level != r_stable_level);
        n_stable_level     = fire ? i_level : r_stable_level;
        o_evt.press        = fire && !i_level;
        o_evt.release_edge = fire && i_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_last     <= 1'b1;
            r_stable_level <= 1'b1;
            r_stable_age   <= '0;
        end else if (i_en) begin
            r_raw_last     <= n_raw_last;
            r_stable_level <= n_stable_level;
            r_stable_age   <= n_stable_age;
        end
    end

endmodule

FILE: design/esseq_core.sv
// ----------------------------------------------------------------------------
// esseq_core
// Phase machine, down-timers, relay latches and LED blinker. Computes the
// state after one item and the result that item produces.
// ----------------------------------------------------------------------------
module esseq_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [esseq_pkg::MODE_W-1:0]  i_mode,
    input  logic                          i_engine_value,
    input  esseq_pkg::t_btn_evt           i_evt,
    input  esseq_pkg::t_cfg               i_cfg,
    output esseq_pkg::t_result            o_result
);

    logic [esseq_pkg::PHASE_W-1:0] r_phase,    n_phase;
    logic [esseq_pkg::TIMER_W-1:0] r_phase_tm, n_phase_tm;
    logic [esseq_pkg::TIMER_W-1:0] r_win_tm,   n_win_tm;
    logic [esseq_pkg::TIMER_W-1:0] r_led_tm,   n_led_tm;
    logic                          r_led,      n_led;
    logic                          r_fast,     n_fast;
    logic                          r_engine,   n_engine;
    logic                          r_hold,     n_hold;
    logic                          r_acc,      n_acc;
    logic                          r_ig,       n_ig;
    logic                          r_starter,  n_starter;
    logic                          rep_valid;
    logic                          rep_value;
    logic                          rst_pulse;

    always_comb begin
        n_phase    = r_phase;
        n_phase_tm = r_phase_tm;
        n_win_tm   = r_win_tm;
        n_led_tm   = r_led_tm;
        n_led      = r_led;
        n_fast     = r_fast;
        n_engine   = r_engine;
        n_hold     = r_hold;
        n_acc      = r_acc;
        n_ig       = r_ig;
        n_starter  = r_starter;
        rep_valid  = 1'b0;
        rep_value  = 1'b0;
        rst_pulse  = 1'b0;

        case (i_mode)
            esseq_pkg::MODE_TICK: begin
                // saturating down-counts
                n_phase_tm = (r_phase_tm != '0) ? r_phase_tm - 1'b1 : '0;
                n_win_tm   = (r_win_tm != '0) ? r_win_tm - 1'b1 : '0;
                n_led_tm   = (r_led_tm != '0) ? r_led_tm - 1'b1 : '0;

                if (n_led_tm == '0) begin
                    n_led = !r_led;
                    if (r_fast) begin
                        n_led_tm = n_led ? i_cfg.fast_on_ms : i_cfg.fast_off_ms;
                    end else begin
                        n_led_tm = i_cfg.slow_blink_ms;
                    end
                end

                if (i_evt.press) begin
                    if (r_engine) begin
                        rst_pulse = 1'b1;
                    end else if (r_phase == esseq_pkg::PH_IDLE) begin
                        n_acc      = 1'b1;
                        rep_valid  = 1'b1;
                        n_phase    = esseq_pkg::PH_ACC;
                        n_phase_tm = i_cfg.acc_wait_ms;
                        n_win_tm   = i_cfg.countdown_ms;
                        n_fast     = 1'b0;
                    end else if (r_phase == esseq_pkg::PH_COUNT) begin
                        // manual starter hold
                        n_starter = 1'b1;
                        n_hold    = 1'b1;
                        n_win_tm  = i_cfg.countdown_ms;
                        n_fast    = 1'b1;
                    end
                end else if (i_evt.release_edge) begin
                    if (r_hold && r_phase == esseq_pkg::PH_COUNT) begin
                        n_starter = 1'b0;
                        n_hold    = 1'b0;
                        n_fast    = 1'b1;
                    end
                end

                // one phase step on the post-edge state
                case (n_phase)
                    esseq_pkg::PH_ACC: begin
                        if (n_phase_tm == '0) begin
                            n_ig       = 1'b1;
                            n_phase    = esseq_pkg::PH_IG;
                            n_phase_tm = i_cfg.ig_wait_ms;
                        end
                    end
                    esseq_pkg::PH_IG: begin
                        if (n_phase_tm == '0) begin
                            n_starter  = 1'b1;
                            n_phase    = esseq_pkg::PH_STARTER;
                            n_phase_tm = i_cfg.starter_pulse_ms;
                            n_fast     = 1'b1;
                        end
                    end
                    esseq_pkg::PH_STARTER: begin
                        if (n_phase_tm == '0) begin
                            n_starter = 1'b0;
                            n_phase   = esseq_pkg::PH_COUNT;
                            n_fast    = 1'b1;
                        end
                    end
                    esseq_pkg::PH_COUNT: begin
                        if (n_win_tm == '0) begin
                            rep_valid = 1'b1;
                            rep_value = 1'b1;
                            n_engine  = 1'b1;
                            n_phase   = esseq_pkg::PH_IDLE;
                            n_fast    = 1'b0;
                            n_starter = 1'b0;
                            n_hold    = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            esseq_pkg::MODE_TRIG: begin
                if (r_engine) begin
                    rst_pulse = 1'b1;
                end else if (r_phase == esseq_pkg::PH_IDLE) begin
                    n_acc      = 1'b1;
                    rep_valid  = 1'b1;
                    n_phase    = esseq_pkg::PH_ACC;
                    n_phase_tm = i_cfg.acc_wait_ms;
                    n_win_tm   = i_cfg.countdown_ms;
                    n_fast     = 1'b0;
                end else if (r_phase == esseq_pkg::PH_COUNT) begin
                    // restart the starter pulse, hold flag kept
                    n_starter  = 1'b1;
                    n_phase    = esseq_pkg::PH_STARTER;
                    n_phase_tm = i_cfg.starter_pulse_ms;
                    n_win_tm   = i_cfg.countdown_ms;
                    n_fast     = 1'b1;
                end
            end
            esseq_pkg::MODE_ENG: begin
                n_engine = i_engine_value;
            end
            default: begin
            end
        endcase

        o_result.phase               = n_phase;
        o_result.engine_running      = n_engine;
        o_result.engine_report_value = rep_value;
        o_result.engine_report_valid = rep_valid;
        o_result.reset_pulse         = rst_pulse;
        o_result.led_out             = n_led;
        o_result.starter_out         = n_starter;
        o_result.ig_out              = n_ig;
        o_result.acc_out             = n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= esseq_pkg::PH_IDLE;
            r_phase_tm <= '0;
            r_win_tm   <= '0;
            r_led_tm   <= esseq_pkg::RST_SLOW;
            r_led      <= 1'b0;
            r_fast     <= 1'b0;
            r_engine   <= 1'b0;
            r_hold     <= 1'b0;
            r_acc      <= 1'b0;
            r_ig       <= 1'b0;
            r_starter  <= 1'b0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_phase_tm <= n_phase_tm;
            r_win_tm   <= n_win_tm;
            r_led_tm   <= n_led_tm;
            r_led      <= n_led;
            r_fast     <= n_fast;
            r_engine   <= n_engine;
            r_hold     <= n_hold;
            r_acc      <= n_acc;
            r_ig       <= n_ig;
            r_starter  <= n_starter;
        end
    end

endmodule

FILE: design/engine_start_sequencer_unit.sv
// a result appears on m_tvalid in the cycle after its item is accepted
// throughput: one item per cycle while m_tready drains the result register; all
// state updates in a single pass between the state registers and the result register
// the result register keeps its item only while m_tready is low; s_tready is high
// whenever the result register is empty or being drained
// reset (i_rst_n, synchronous, active low) clears all state and loads the register defaults
// ----------------------------------------------------------------------------
// engine_start_sequencer_unit
// Push-button engine start sequencer: debounced button edges and start
// triggers drive accessory, ignition, starter and countdown phases.
// ----------------------------------------------------------------------------
module engine_start_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] button_level, [1] engine_value
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] acc_out, [1] ig_out, [2] starter_out, [3] led_out, [4] reset_pulse,
    // [5] engine_report_valid, [6] engine_report_value, [7] engine_running,
    // [10:8] phase
    output logic [15:0] m_tdata
);

    esseq_pkg::t_cfg      r_cfg;
    esseq_pkg::t_btn_evt  evt;
    esseq_pkg::t_result   result;

    logic                               r_m_valid;
    logic [15:0]                        r_m_data;
    logic                               accept;
    logic                               cfg_wr;
    logic [esseq_pkg::REG_W-1:0]        reg_idx;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[4:2];
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = !r_m_valid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms      <= esseq_pkg::RST_DEBOUNCE;
            r_cfg.countdown_ms     <= esseq_pkg::RST_COUNTDOWN;
            r_cfg.acc_wait_ms      <= esseq_pkg::RST_ACC_WAIT;
            r_cfg.ig_wait_ms       <= esseq_pkg::RST_IG_WAIT;
            r_cfg.starter_pulse_ms <= esseq_pkg::RST_STARTER;
            r_cfg.slow_blink_ms    <= esseq_pkg::RST_SLOW;
            r_cfg.fast_on_ms       <= esseq_pkg::RST_FAST_ON;
            r_cfg.fast_off_ms      <= esseq_pkg::RST_FAST_OFF;
        end else if (cfg_wr) begin
            case (reg_idx)
                esseq_pkg::REG_DEBOUNCE:  r_cfg.debounce_ms      <= pwdata[9:0];
                esseq_pkg::REG_COUNTDOWN: r_cfg.countdown_ms     <= pwdata[15:0];
                esseq_pkg::REG_ACC_WAIT:  r_cfg.acc_wait_ms      <= pwdata[15:0];
                esseq_pkg::REG_IG_WAIT:   r_cfg.ig_wait_ms       <= pwdata[15:0];
                esseq_pkg::REG_STARTER:   r_cfg.starter_pulse_ms <= pwdata[15:0];
                esseq_pkg::REG_SLOW:      r_cfg.slow_blink_ms    <= pwdata[15:0];
                esseq_pkg::REG_FAST_ON:   r_cfg.fast_on_ms       <= pwdata[15:0];
                esseq_pkg::REG_FAST_OFF:  r_cfg.fast_off_ms      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            esseq_pkg::REG_DEBOUNCE:  prdata = {22'd0, r_cfg.debounce_ms};
            esseq_pkg::REG_COUNTDOWN: prdata = {16'd0, r_cfg.countdown_ms};
            esseq_pkg::REG_ACC_WAIT:  prdata = {16'd0, r_cfg.acc_wait_ms};
            esseq_pkg::REG_IG_WAIT:   prdata = {16'd0, r_cfg.ig_wait_ms};
            esseq_pkg::REG_STARTER:   prdata = {16'd0, r_cfg.starter_pulse_ms};
            esseq_pkg::REG_SLOW:      prdata = {16'd0, r_cfg.slow_blink_ms};
            esseq_pkg::REG_FAST_ON:   prdata = {16'd0, r_cfg.fast_on_ms};
            esseq_pkg::REG_FAST_OFF:  prdata = {16'd0, r_cfg.fast_off_ms};
            default:                  prdata = '0;
        endcase
    end

    esseq_debounce u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (accept && (s_tuser == esseq_pkg::MODE_TICK)),
        .i_level       (s_tdata[0]),
        .i_debounce_ms (r_cfg.debounce_ms),
        .o_evt         (evt)
    );

    esseq_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (accept),
        .i_mode         (s_tuser),
        .i_engine_value (s_tdata[1]),
        .i_evt          (evt),
        .i_cfg          (r_cfg),
        .o_result       (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_data <= {5'd0, result};
        end
    end

`ifndef SYNTHESIS
    // a report value of one only comes with a valid report
    a_report_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[6] |-> m_tdata[5])
        else $error("report value without report valid");

    // an external reset is only requested while the engine is on
    a_reset_engine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[7])
        else $error("reset pulse with engine off");

    // ignition relay is latched only after the accessory relay
    a_ig_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("ignition on without accessory");

    // the phase machine only reaches the five defined phases
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[10:8] <= esseq_pkg::PH_COUNT))
        else $error("phase out of range");
`endif

endmodule
